@@ rtl/core/bc3_pkg.sv @@
// Shared types, constants and arithmetic helpers for the BC3 block decoder.
// Used by every module under rtl/core except bc3_checker; depends on nothing else.
package bc3_pkg;

   // Dimension clamp, block geometry and field widths.
   localparam int MAX_IMAGE_SIZE = 16384;
   localparam int NUM_TEXELS     = 16;
   localparam int SEL_W          = $clog2(NUM_TEXELS);
   localparam int CFG_W          = 15;
   localparam int COORD_W        = 14;
   localparam int POS_W          = 16;

   // Register select codes, taken from paddr bit 2.
   localparam logic REG_WIDTH  = 1'b0;
   localparam logic REG_HEIGHT = 1'b1;

   // Fixed alpha levels of the six-level palette.
   localparam logic [7:0] ALPHA_ZERO = 8'h00;
   localparam logic [7:0] ALPHA_FULL = 8'hFF;

   // Reciprocal multipliers for division by 3, 5 and 7 over the numerator ranges used here.
   localparam logic [20:0] DIV3_MUL = 21'd1366;
   localparam logic [21:0] DIV5_MUL = 22'd3277;
   localparam logic [21:0] DIV7_MUL = 22'd2341;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      rgb_type [3:0]   colour;
      logic [7:0][7:0] alpha;
   } palette_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rgba_type;

   typedef struct packed {
      logic     keep;
      rgba_type texel;
   } lane_out_type;

   typedef struct packed {
      logic [COORD_W-1:0] x0;
      logic [COORD_W-1:0] y0;
   } blk_pos_type;

   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      rgba_type           texel;
      logic               last;
   } texel_out_type;

   // RGB565 to 8-bit channels by plain left shifts.
   function automatic rgb_type widen565(input logic [15:0] c);
      rgb_type v;
      v.red   = {c[15:11], 3'b000};
      v.green = {c[10:5], 2'b00};
      v.blue  = {c[4:0], 3'b000};
      return v;
   endfunction

   // Rounded (2p + q) / 3.
   function automatic logic [7:0] interp3(input logic [7:0] p, input logic [7:0] q);
      logic [9:0]  n;
      logic [20:0] prod;
      n    = {1'b0, p, 1'b0} + {2'b00, q} + 10'd1;
      prod = 21'(n) * DIV3_MUL;
      return prod[19:12];
   endfunction

   // Rounded weighted alpha in sevenths.
   function automatic logic [7:0] mix7(input logic [7:0] a0, input logic [7:0] a1,
                                       input logic [2:0] w0, input logic [2:0] w1);
      logic [10:0] n;
      logic [21:0] prod;
      n    = 11'(w0) * 11'(a0) + 11'(w1) * 11'(a1) + 11'd3;
      prod = 22'(n) * DIV7_MUL;
      return prod[21:14];
   endfunction

   // Rounded weighted alpha in fifths.
   function automatic logic [7:0] mix5(input logic [7:0] a0, input logic [7:0] a1,
                                       input logic [2:0] w0, input logic [2:0] w1);
      logic [10:0] n;
      logic [21:0] prod;
      n    = 11'(w0) * 11'(a0) + 11'(w1) * 11'(a1) + 11'd2;
      prod = 22'(n) * DIV5_MUL;
      return prod[21:14];
   endfunction

endpackage

@@ rtl/core/bc3_block_decoder.sv @@
// BC3 block decoder top level: configuration registers, block position, palette stage,
// sixteen texel lanes and the merge stage. Depends on bc3_pkg and the bc3_* submodules.
// Path of a block: palette stage register, merge buffer, then the output register.
// Throughput: one texel per cycle while rsp_tready is high, set by the single output port;
// a block holds the merge stage until its in-range texels (16 if interior) have been sent.
// Reset (synchronous) empties the pipeline, sets width and height to 4 and the position to 0.
module bc3_block_decoder (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // [63:0] alpha_half, [127:64] colour_half
   // Result channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [63:0]  rsp_tdata,   // [13:0] pixel_x, [27:14] pixel_y, [35:28] red,
                                     // [43:36] green, [51:44] blue, [59:52] alpha, [63:60] 0
   output logic         rsp_tlast,   // last
   // Configuration port.
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import bc3_pkg::*;

   logic [CFG_W-1:0]            width_ff, width_in;
   logic [CFG_W-1:0]            height_ff, height_in;
   logic [COORD_W-1:0]          col_ff, col_in;
   logic [COORD_W-1:0]          row_ff, row_in;

   logic                        s2_valid_ff, s2_valid_in;
   palette_type                 s2_palette_ff, s2_palette_in;
   logic [31:0]                 s2_cidx_ff, s2_cidx_in;
   logic [47:0]                 s2_aidx_ff, s2_aidx_in;
   logic [POS_W-1:0]            s2_x0_ff, s2_x0_in;
   logic [POS_W-1:0]            s2_y0_ff, s2_y0_in;

   logic                        cfg_write;
   logic [CFG_W-1:0]            eff_w;
   logic [CFG_W-1:0]            eff_h;
   logic [CFG_W:0]              col_next;
   logic [COORD_W-1:0]          row_next;
   logic                        req_accept;
   logic                        merge_ready;
   palette_type                 palette;
   lane_out_type [NUM_TEXELS-1:0] lanes;
   blk_pos_type                 blk_pos;
   texel_out_type               out_data;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (cfg_write) begin
         case (csr_paddr[2])
            REG_WIDTH:  width_in  = csr_pwdata[CFG_W-1:0];
            REG_HEIGHT: height_in = csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_WIDTH:  csr_prdata = {{(32-CFG_W){1'b0}}, width_ff};
         REG_HEIGHT: csr_prdata = {{(32-CFG_W){1'b0}}, height_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // Dimensions clamped to the largest supported image.
   assign eff_w = (int'(width_ff) > MAX_IMAGE_SIZE) ? CFG_W'(MAX_IMAGE_SIZE) : width_ff;
   assign eff_h = (int'(height_ff) > MAX_IMAGE_SIZE) ? CFG_W'(MAX_IMAGE_SIZE) : height_ff;

   // Request handshake; the palette stage frees up as the merge stage takes its block.
   assign req_tready = !s2_valid_ff || merge_ready;
   assign req_accept = req_tvalid && req_tready;

   // Raster walk over blocks; wraps to the next row and then to the next image.
   assign col_next = {1'b0, col_ff} + {{CFG_W{1'b0}}, 1'b1};
   assign row_next = row_ff + {{(COORD_W-1){1'b0}}, 1'b1};

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if ({col_next, 2'b00} >= {3'b000, eff_w}) begin
            col_in = '0;
            row_in = ({row_next, 2'b00} >= {1'b0, eff_h}) ? '0 : row_next;
         end else begin
            col_in = col_next[COORD_W-1:0];
         end
      end
   end

   // Palette stage.
   bc3_palette u_palette (
      .alpha_half  (req_tdata[63:0]),
      .colour_half (req_tdata[127:64]),
      .palette     (palette)
   );

   always_comb begin
      s2_valid_in   = s2_valid_ff;
      s2_palette_in = s2_palette_ff;
      s2_cidx_in    = s2_cidx_ff;
      s2_aidx_in    = s2_aidx_ff;
      s2_x0_in      = s2_x0_ff;
      s2_y0_in      = s2_y0_ff;
      if (req_accept) begin
         s2_valid_in   = 1'b1;
         s2_palette_in = palette;
         s2_cidx_in    = req_tdata[127:96];
         s2_aidx_in    = req_tdata[63:16];
         s2_x0_in      = {col_ff, 2'b00};
         s2_y0_in      = {row_ff, 2'b00};
      end else if (merge_ready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= CFG_W'(4);
         height_ff   <= CFG_W'(4);
         col_ff      <= '0;
         row_ff      <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_palette_ff <= s2_palette_in;
      s2_cidx_ff    <= s2_cidx_in;
      s2_aidx_ff    <= s2_aidx_in;
      s2_x0_ff      <= s2_x0_in;
      s2_y0_ff      <= s2_y0_in;
   end

   // Sixteen texel lanes, one per texel of the block.
   for (genvar g = 0; g < NUM_TEXELS; g++) begin : g_lane
      bc3_lane u_lane (
         .palette      (s2_palette_ff),
         .colour_index (s2_cidx_ff[2*g +: 2]),
         .alpha_index  (s2_aidx_ff[3*g +: 3]),
         .x0           (s2_x0_ff),
         .y0           (s2_y0_ff),
         .lane_col     (2'(g % 4)),
         .lane_row     (2'(g / 4)),
         .width        (eff_w),
         .height       (eff_h),
         .result       (lanes[g])
      );
   end

   assign blk_pos.x0 = s2_x0_ff[COORD_W-1:0];
   assign blk_pos.y0 = s2_y0_ff[COORD_W-1:0];

   // Merge stage and output register.
   bc3_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load_valid (s2_valid_ff),
      .load_ready (merge_ready),
      .lanes      (lanes),
      .blk_pos    (blk_pos),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (out_data)
   );

   assign rsp_tdata = {4'b0000, out_data.texel.alpha, out_data.texel.blue,
                       out_data.texel.green, out_data.texel.red,
                       out_data.pixel_y, out_data.pixel_x};
   assign rsp_tlast = out_data.last;

endmodule

@@ rtl/core/bc3_palette.sv @@
// Builds the four-entry colour palette and eight-entry alpha palette of one block.
// Depends on bc3_pkg.
module bc3_palette (
   input  logic [63:0]          alpha_half,
   input  logic [63:0]          colour_half,
   output bc3_pkg::palette_type palette
);
   import bc3_pkg::*;

   rgb_type    c0;
   rgb_type    c1;
   logic [7:0] a0;
   logic [7:0] a1;

   assign c0 = widen565(colour_half[15:0]);
   assign c1 = widen565(colour_half[31:16]);
   assign a0 = alpha_half[7:0];
   assign a1 = alpha_half[15:8];

   // Colour endpoints plus the two thirds, always in four-colour mode.
   always_comb begin
      palette.colour[0]       = c0;
      palette.colour[1]       = c1;
      palette.colour[2].red   = interp3(c0.red, c1.red);
      palette.colour[2].green = interp3(c0.green, c1.green);
      palette.colour[2].blue  = interp3(c0.blue, c1.blue);
      palette.colour[3].red   = interp3(c1.red, c0.red);
      palette.colour[3].green = interp3(c1.green, c0.green);
      palette.colour[3].blue  = interp3(c1.blue, c0.blue);

      // Alpha: eight levels when alpha0 exceeds alpha1, else six levels plus 0 and 255.
      palette.alpha[0] = a0;
      palette.alpha[1] = a1;
      for (int k = 2; k < 8; k++) begin
         if (a0 > a1) begin
            palette.alpha[k] = mix7(a0, a1, 3'(8 - k), 3'(k - 1));
         end else if (k < 6) begin
            palette.alpha[k] = mix5(a0, a1, 3'(6 - k), 3'(k - 1));
         end else if (k == 6) begin
            palette.alpha[k] = ALPHA_ZERO;
         end else begin
            palette.alpha[k] = ALPHA_FULL;
         end
      end
   end

endmodule

@@ rtl/core/bc3_lane.sv @@
// One texel lane: looks up colour and alpha and checks the texel against the image.
// Depends on bc3_pkg.
module bc3_lane (
   input  bc3_pkg::palette_type                palette,
   input  logic [1:0]                          colour_index,
   input  logic [2:0]                          alpha_index,
   input  logic [bc3_pkg::POS_W-1:0]           x0,
   input  logic [bc3_pkg::POS_W-1:0]           y0,
   input  logic [1:0]                          lane_col,
   input  logic [1:0]                          lane_row,
   input  logic [bc3_pkg::CFG_W-1:0]           width,
   input  logic [bc3_pkg::CFG_W-1:0]           height,
   output bc3_pkg::lane_out_type               result
);
   import bc3_pkg::*;

   logic [POS_W-1:0] px;
   logic [POS_W-1:0] py;

   // Image position of this texel.
   assign px = x0 + {{(POS_W-2){1'b0}}, lane_col};
   assign py = y0 + {{(POS_W-2){1'b0}}, lane_row};

   // Palette lookup and range check.
   always_comb begin
      result.keep        = (px < POS_W'(width)) && (py < POS_W'(height));
      result.texel.red   = palette.colour[colour_index].red;
      result.texel.green = palette.colour[colour_index].green;
      result.texel.blue  = palette.colour[colour_index].blue;
      result.texel.alpha = palette.alpha[alpha_index];
   end

endmodule

@@ rtl/core/bc3_merge.sv @@
// Collects the sixteen lane results of a block and emits the kept texels in row order.
// Depends on bc3_pkg; holds the texel buffer and the output register.
module bc3_merge (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          load_valid,
   output logic                                          load_ready,
   input  bc3_pkg::lane_out_type [bc3_pkg::NUM_TEXELS-1:0] lanes,
   input  bc3_pkg::blk_pos_type                          blk_pos,
   output logic                                          out_valid,
   input  logic                                          out_ready,
   output bc3_pkg::texel_out_type                        out_data
);
   import bc3_pkg::*;

   logic [NUM_TEXELS-1:0]             mask_ff, mask_in;
   rgba_type [NUM_TEXELS-1:0]         texel_ff, texel_in;
   blk_pos_type                       pos_ff, pos_in;
   logic                              out_valid_ff, out_valid_in;
   texel_out_type                     out_data_ff, out_data_in;

   logic [SEL_W-1:0]                  sel;
   logic [NUM_TEXELS-1:0]             rest;
   logic [NUM_TEXELS-1:0]             new_mask;
   logic                              out_free;
   logic                              emit;
   logic                              load;

   // First kept texel still waiting in the buffer.
   always_comb begin
      sel = '0;
      for (int i = NUM_TEXELS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = SEL_W'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_TEXELS; i++) begin
         new_mask[i] = lanes[i].keep;
      end
   end

   // Emission and buffer handover; a new block loads as the old one sends its last texel.
   assign out_free   = !out_valid_ff || out_ready;
   assign emit       = (|mask_ff) && out_free;
   assign rest       = mask_ff & ~({{(NUM_TEXELS-1){1'b0}}, 1'b1} << sel);
   assign load_ready = (mask_ff == '0) || (emit && (rest == '0));
   assign load       = load_valid && load_ready;

   always_comb begin
      mask_in  = mask_ff;
      texel_in = texel_ff;
      pos_in   = pos_ff;
      if (load) begin
         mask_in = new_mask;
         pos_in  = blk_pos;
         for (int i = 0; i < NUM_TEXELS; i++) begin
            texel_in[i] = lanes[i].texel;
         end
      end else if (emit) begin
         mask_in = rest;
      end
   end

   // Output register.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (emit) begin
         out_valid_in        = 1'b1;
         out_data_in.pixel_x = pos_ff.x0 + {{(COORD_W-2){1'b0}}, sel[1:0]};
         out_data_in.pixel_y = pos_ff.y0 + {{(COORD_W-2){1'b0}}, sel[3:2]};
         out_data_in.texel   = texel_ff[sel];
         out_data_in.last    = (rest == '0);
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      texel_ff    <= texel_in;
      pos_ff      <= pos_in;
      out_data_ff <= out_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

@@ rtl/core/bc3_checker.sv @@
// Port-level checks for the BC3 block decoder, bound to the top level.
// Depends only on the top level's ports.
module bc3_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Reset empties the output register.
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // Reset empties the palette stage, so a request is taken at once.
   a_req_reset: assert property (@(posedge clock) reset |=> req_tready)
      else $error("request not ready right after reset");

   // Texels of one block follow each other without gaps.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid)
      else $error("gap inside a block");

endmodule

bind bc3_block_decoder bc3_checker u_checker (.*);
